@@ design/sgr_pkg.sv @@
package sgr_pkg;

    localparam int MAX_GROUP = 16;
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int IDX_W     = $clog2(MAX_GROUP);
    localparam int WORD_W    = 32;
    localparam int SIZE_W    = 5;

    localparam logic [SIZE_W-1:0] GROUP_SIZE_RST = SIZE_W'(2);

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

    function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
        logic [CNT_W-1:0] k;
        if (size == '0) begin
            k = CNT_W'(1);
        end else if (32'(size) > MAX_GROUP) begin
            k = CNT_W'(MAX_GROUP);
        end else begin
            k = CNT_W'(size);
        end
        return k;
    endfunction

endpackage

@@ design/sgr_cell.sv @@
module sgr_cell (
    input  logic              i_clk,
    input  sgr_pkg::t_cell_ctl i_ctl,
    input  sgr_pkg::t_word    i_from_below,
    input  sgr_pkg::t_word    i_from_above,
    output sgr_pkg::t_word    o_q
);

    sgr_pkg::t_word r_q;
    sgr_pkg::t_word n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctl.push) begin
            n_q = i_from_below;
        end else if (i_ctl.pop) begin
            n_q = i_from_above;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

@@ design/sgr_row.sv @@
module sgr_row (
    input  logic                        i_clk,
    input  sgr_pkg::t_cell_ctl          i_ctl,
    input  sgr_pkg::t_word              i_value,
    input  logic [sgr_pkg::IDX_W-1:0]   i_rd_idx,
    output sgr_pkg::t_word              o_head,
    output sgr_pkg::t_word              o_tap
);

    sgr_pkg::t_word w_q [sgr_pkg::MAX_GROUP];

    for (genvar g = 0; g < sgr_pkg::MAX_GROUP; g++) begin : g_cell
        sgr_pkg::t_word w_below;
        sgr_pkg::t_word w_above;

        if (g == 0) begin : g_first
            assign w_below = i_value;
        end else begin : g_mid
            assign w_below = w_q[g-1];
        end

        if (g == sgr_pkg::MAX_GROUP - 1) begin : g_last
            assign w_above = w_q[g];
        end else begin : g_inner
            assign w_above = w_q[g+1];
        end

        sgr_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_from_below (w_below),
            .i_from_above (w_above),
            .o_q          (w_q[g])
        );
    end

    assign o_head = w_q[0];
    assign o_tap  = w_q[i_rd_idx];

endmodule

@@ design/stream_group_reverser.sv @@
// Input beats are taken one per cycle while a group fills; the newest value
// enters the head cell of a 16-cell shift chain and older values move up.
// A completed group (or the list end) emits n beats, one output beat per cycle while
// the output is not stalled; the edge that takes the completing beat moves the state
// to emission, which loads each beat into the output register and holds input off.
// Synchronous active-low reset clears the fill count, state and output valid and
// sets group_size to 2; cell contents are not reset.
module stream_group_reverser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [31:0]            i_value,
    input  logic                          i_list_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [31:0]            o_out_value,
    output logic                          o_run_last,
    output logic                          o_list_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sgr_pkg::SIZE_W-1:0]    i_cfg_group_size
);

    typedef enum logic {
        ST_FILL,
        ST_EMIT
    } t_state;

    t_state                        r_state;
    logic [sgr_pkg::CNT_W-1:0]     r_count;
    logic                          r_rev;
    logic                          r_end;
    logic [sgr_pkg::SIZE_W-1:0]    r_group_size;
    logic                          r_out_valid;
    sgr_pkg::t_word                r_out_value;
    logic                          r_run_last;
    logic                          r_list_last;

    logic [sgr_pkg::CNT_W-1:0]     n_count;
    logic [sgr_pkg::CNT_W-1:0]     w_k;
    logic [sgr_pkg::CNT_W-1:0]     w_cnt_m1;
    logic                          w_in_fire;
    logic                          w_out_fire;
    logic                          w_load;
    logic                          w_full;
    sgr_pkg::t_cell_ctl            w_ctl;
    sgr_pkg::t_word                w_head;
    sgr_pkg::t_word                w_tap;

    assign o_in_ready  = (r_state == ST_FILL);
    assign o_cfg_ready = 1'b1;
    assign w_in_fire   = i_in_valid & o_in_ready;
    assign w_out_fire  = r_out_valid & i_out_ready;
    assign w_load      = (r_state == ST_EMIT) & (~r_out_valid | i_out_ready);
    assign w_k         = sgr_pkg::eff_size(r_group_size);
    assign n_count     = r_count + sgr_pkg::CNT_W'(1);
    assign w_cnt_m1    = r_count - sgr_pkg::CNT_W'(1);
    assign w_full      = (n_count >= w_k);

    assign w_ctl.push = w_in_fire;
    assign w_ctl.pop  = w_load & r_rev;

    sgr_row u_row (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_value  (i_value),
        .i_rd_idx (w_cnt_m1[sgr_pkg::IDX_W-1:0]),
        .o_head   (w_head),
        .o_tap    (w_tap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_FILL;
            r_count      <= '0;
            r_rev        <= 1'b0;
            r_end        <= 1'b0;
            r_group_size <= sgr_pkg::GROUP_SIZE_RST;
            r_out_valid  <= 1'b0;
            r_run_last   <= 1'b0;
            r_list_last  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_group_size <= i_cfg_group_size;
            end
            if (w_out_fire && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_FILL: begin
                    if (w_in_fire) begin
                        r_count <= n_count;
                        r_rev   <= w_full;
                        r_end   <= i_list_end;
                        if (w_full || i_list_end) begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_rev ? w_head : w_tap;
                        r_run_last  <= (r_count == sgr_pkg::CNT_W'(1));
                        r_list_last <= (r_count == sgr_pkg::CNT_W'(1)) & r_end;
                        r_count     <= w_cnt_m1;
                        if (r_count == sgr_pkg::CNT_W'(1)) begin
                            r_state <= ST_FILL;
                        end
                    end
                end
                default: begin
                    r_state <= ST_FILL;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_run_last  = r_run_last;
    assign o_list_last = r_list_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= sgr_pkg::MAX_GROUP)
        else $error("fill count exceeds group capacity");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_count != '0))
        else $error("emission with empty group");

    a_list_last_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_list_last) |-> o_run_last)
        else $error("list end without run end");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_count == sgr_pkg::CNT_W'(1)) |=>
            (r_state == ST_FILL && r_count == '0 && o_out_valid && o_run_last))
        else $error("group emission did not close");

endmodule

@@ test/sgr_tb_pkg.sv @@
`timescale 1ns / 1ps
package sgr_tb_pkg;

    import sgr_pkg::*;

    typedef struct {
        t_word value;
        logic  run_last;
        logic  list_last;
    } reordered_beat_t;

    class reversal_board;
        t_word             open_group[$];
        reordered_beat_t   due_beats[$];
        logic [SIZE_W-1:0] group_size;
        bit [MAX_GROUP:0]  sizes_used;
        int unsigned       errors;
        int unsigned       values_taken;
        int unsigned       beats_checked;
        int unsigned       reversed_groups;
        int unsigned       kept_groups;

        function new();
            group_size = GROUP_SIZE_RST;
            sizes_used = '0;
            sizes_used[active_size()] = 1'b1;
            errors = 0;
            values_taken = 0;
            beats_checked = 0;
            reversed_groups = 0;
            kept_groups = 0;
        endfunction

        function int unsigned active_size();
            if (group_size == '0) begin
                return 1;
            end
            if (int'(group_size) > MAX_GROUP) begin
                return MAX_GROUP;
            end
            return int'(group_size);
        endfunction

        function void set_size(logic [SIZE_W-1:0] size);
            group_size = size;
            sizes_used[active_size()] = 1'b1;
        endfunction

        function int unsigned pending();
            return due_beats.size();
        endfunction

        function void take_value(t_word value, logic list_end);
            int unsigned n;
            reordered_beat_t beat;
            values_taken++;
            open_group.push_back(value);
            n = open_group.size();
            if (n >= active_size()) begin
                for (int i = 0; i < n; i++) begin
                    beat.value     = open_group[n - 1 - i];
                    beat.run_last  = (i == n - 1);
                    beat.list_last = (i == n - 1) && list_end;
                    due_beats.push_back(beat);
                end
                open_group.delete();
                reversed_groups++;
            end else if (list_end) begin
                for (int i = 0; i < n; i++) begin
                    beat.value     = open_group[i];
                    beat.run_last  = (i == n - 1);
                    beat.list_last = (i == n - 1);
                    due_beats.push_back(beat);
                end
                open_group.delete();
                kept_groups++;
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 30) begin
                $display("MISMATCH beat %0d: %s", beats_checked, what);
            end
        endtask

        task check_beat(t_word value, logic run_last, logic list_last);
            reordered_beat_t want;
            beats_checked++;
            if (due_beats.size() == 0) begin
                report_mismatch($sformatf("no beat due, got value %0d", value));
                return;
            end
            want = due_beats.pop_front();
            if (value !== want.value) begin
                report_mismatch($sformatf("value %0d, want %0d", value, want.value));
            end
            if (run_last !== want.run_last) begin
                report_mismatch($sformatf("run_last %b, want %b", run_last, want.run_last));
            end
            if (list_last !== want.list_last) begin
                report_mismatch($sformatf("list_last %b, want %b", list_last, want.list_last));
            end
        endtask

        task check_drained();
            if (due_beats.size() != 0) begin
                report_mismatch($sformatf("%0d beats never came", due_beats.size()));
            end
        endtask
    endclass

endpackage

@@ test/stream_group_reverser_tb.sv @@
`timescale 1ns / 1ps
module stream_group_reverser_tb;

    import sgr_pkg::*;
    import sgr_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS = 275;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_word             i_value;
    logic              i_list_end;
    logic              o_out_valid;
    logic              i_out_ready;
    t_word             o_out_value;
    logic              o_run_last;
    logic              o_list_last;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_group_size;

    reversal_board board;
    bit            steady = 1'b0;
    int unsigned   cycles = 0;
    int unsigned   lists_sent = 0;
    int unsigned   size_writes = 0;

    stream_group_reverser i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_value          (i_value),
        .i_list_end       (i_list_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_value      (o_out_value),
        .o_run_last       (o_run_last),
        .o_list_last      (o_list_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_group_size (i_cfg_group_size)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 22);
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_beat(o_out_value, o_run_last, o_list_last);
        end
    end

    task automatic send_beat(input t_word value, input logic list_end);
        logic took;
        while (!steady && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        i_list_end <= list_end;
        do begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end while (!took);
        board.take_value(value, list_end);
        if (list_end) begin
            lists_sent++;
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_group_size(input logic [SIZE_W-1:0] size);
        logic took;
        settle();
        i_cfg_valid      <= 1'b1;
        i_cfg_group_size <= size;
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end while (!took);
        i_cfg_valid <= 1'b0;
        board.set_size(size);
        size_writes++;
    endtask

    task automatic send_list(input int unsigned len, input bit closed);
        t_word value;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0: value = 32'sh7FFF_FFFF;
                1: value = 32'sh8000_0000;
                2: value = '0;
                3: value = -1;
                default: value = t_word'($urandom);
            endcase
            send_beat(value, closed && (i == len - 1));
        end
    endtask

    initial begin
        int unsigned sent;
        int unsigned len;
        int unsigned phase;
        logic [SIZE_W-1:0] size;

        board            = new();
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_value          = '0;
        i_list_end       = 1'b0;
        i_out_ready      = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_group_size = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(32'sh7FFF_FFFF, 1'b0);
        send_beat(32'sh8000_0000, 1'b1);
        send_beat(5, 1'b1);
        write_group_size(0);
        send_beat(-1, 1'b0);
        send_beat(0, 1'b1);
        write_group_size(5);
        send_beat(11, 1'b0);
        send_beat(22, 1'b0);
        send_beat(33, 1'b0);
        // lower the size below what is already held
        write_group_size(2);
        send_beat(44, 1'b0);
        send_beat(55, 1'b1);
        write_group_size(17);
        send_list(16, 1'b1);
        write_group_size(31);
        send_list(2, 1'b1);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(5))
                0: size = 1;
                1: size = 16;
                default: size = SIZE_W'($urandom_range(31));
            endcase
            write_group_size(size);
            steady = (phase == 2);
            for (int n = 0; n < 40 && sent < RANDOM_ITEMS; n += len) begin
                len = $urandom_range(1, 24);
                send_list(len, 1'b1);
                sent += len;
                if (phase == 3 && n == 0) begin
                    settle();
                end
            end
            if ($urandom_range(2) == 0) begin
                len = $urandom_range(1, 5);
                send_list(len, 1'b0);
                sent += len;
            end
            steady = 1'b0;
            phase++;
        end
        send_beat(t_word'($urandom), 1'b1);
        settle();
        repeat (20) @(posedge i_clk);
        board.check_drained();

        $display("Sent %0d values in %0d lists over %0d size writes; checked %0d beats.",
                 board.values_taken, lists_sent, size_writes, board.beats_checked);
        $display("Groups reversed %0d, partial groups kept in order %0d, sizes hit %0d of %0d.",
                 board.reversed_groups, board.kept_groups,
                 $countones(board.sizes_used), MAX_GROUP);
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/sgr_pkg.sv
design/sgr_cell.sv
design/sgr_row.sv
design/stream_group_reverser.sv
test/sgr_tb_pkg.sv
test/stream_group_reverser_tb.sv
